/* rtl/gsa_pkg.sv */
// Shared constants, field widths and request codes of the generational slot allocator.
package gsa_pkg;

   localparam int SLOTS_DEFAULT    = 64;
   localparam int GEN_BITS_DEFAULT = 16;

   localparam int ACTION_W  = 2;
   localparam int HANDLE_W  = 16;
   localparam int OUT_IDX_W = 6;
   localparam int OUT_GEN_W = 16;
   localparam int FREE_W    = 7;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_ALLOC   = 2'd0;
   localparam action_type ACT_RELEASE = 2'd1;
   localparam action_type ACT_CHECK   = 2'd2;

endpackage

/* rtl/gsa_if.sv */
// Valid/ready channel interfaces for allocator requests and responses.
interface gsa_req_if;
   import gsa_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [HANDLE_W-1:0] handle_index;
   logic [HANDLE_W-1:0] handle_generation;

   modport source (output valid, action, handle_index, handle_generation, input ready);
   modport sink   (input valid, action, handle_index, handle_generation, output ready);
endinterface

interface gsa_rsp_if;
   import gsa_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [OUT_IDX_W-1:0] slot_index;
   logic [OUT_GEN_W-1:0] slot_generation;
   logic [FREE_W-1:0]    free_slots;

   modport source (output valid, ok, slot_index, slot_generation, free_slots, input ready);
   modport sink   (input valid, ok, slot_index, slot_generation, free_slots, output ready);
endinterface

/* rtl/gsa_slot_table.sv */
// Per-slot table RAM holding the busy bit and generation counter, registered read.
module gsa_slot_table #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEFAULT,
   parameter int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic                wr_busy,
   input  logic [GEN_BITS-1:0] wr_gen,
   output logic                rd_busy,
   output logic [GEN_BITS-1:0] rd_gen
);
   import gsa_pkg::*;

   logic [GEN_BITS:0] table_mem [SLOTS];
   logic [GEN_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= {wr_busy, wr_gen};
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_busy = rd_data_ff[GEN_BITS];
   assign rd_gen  = rd_data_ff[GEN_BITS-1:0];

endmodule

/* rtl/generational_slot_allocator.sv */
// Top level of the generational slot allocator: free stack, sequencer and response register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------------
//  req_ch   | in  | valid/ready        | action, handle_index, handle_generation
//  rsp_ch   | out | valid/ready        | ok, slot_index, slot_generation, free_slots
//
// One request is in flight at a time. Release, check, a failed allocate or an unused
// code pass from the look step straight back to idle; a successful allocate also
// passes the claim step, as the stack read and the slot table read are chained.
// The response register frees the sequencer: the next request is taken while a
// response waits; a request whose response cannot be loaded holds in its last step.
// Reset is synchronous. Neither RAM is cleared: a low-water mark of the stack pointer
// tells which stack entries and which slots were ever written, and unwritten ones
// read as their reset contents.
module generational_slot_allocator #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   gsa_req_if.sink        req_ch,
   gsa_rsp_if.source      rsp_ch
);
   import gsa_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (GEN_BITS > HANDLE_W) ? GEN_BITS : HANDLE_W;

   localparam logic [CNT_W-1:0]    SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0]    LAST_CNT  = CNT_W'(SLOTS - 1);
   localparam logic [HANDLE_W-1:0] SLOTS_H   = HANDLE_W'(SLOTS);

   // sequencer steps
   localparam logic [1:0] S_IDLE  = 2'd0;  // wait for a request, issue first read
   localparam logic [1:0] S_LOOK  = 2'd1;  // stack or table data back
   localparam logic [1:0] S_CLAIM = 2'd2;  // allocate: table data of the popped slot back

   logic [1:0]          state_ff, state_in;
   action_type          act_ff, act_in;
   logic [HANDLE_W-1:0] idx_ff, idx_in;
   logic [HANDLE_W-1:0] hgen_ff, hgen_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]    free_top_ff, free_top_in;
   logic [CNT_W-1:0]    low_mark_ff, low_mark_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [OUT_GEN_W-1:0] rsp_gen_ff, rsp_gen_in;
   logic [FREE_W-1:0]    rsp_free_ff, rsp_free_in;

   // free stack RAM
   logic [IDX_W-1:0] stack_mem [SLOTS];
   logic [IDX_W-1:0] stack_rd_ff;
   logic             stack_rd_en;
   logic [IDX_W-1:0] stack_rd_addr;
   logic             stack_wr_en;
   logic [IDX_W-1:0] stack_wr_addr;
   logic [IDX_W-1:0] stack_wr_data;

   // slot table port
   logic                tbl_rd_en;
   logic [IDX_W-1:0]    tbl_rd_addr;
   logic                tbl_wr_en;
   logic [IDX_W-1:0]    tbl_wr_addr;
   logic                tbl_wr_busy;
   logic [GEN_BITS-1:0] tbl_wr_gen;
   logic                tbl_rd_busy;
   logic [GEN_BITS-1:0] tbl_rd_gen;

   logic                accept;
   logic                out_free;
   logic [CNT_W-1:0]    top_pos;
   logic [IDX_W-1:0]    pop_pos;
   logic [IDX_W-1:0]    pop_slot;
   logic [CNT_W-1:0]    fresh_cnt;
   logic                in_range;
   logic                look_written;
   logic                look_busy;
   logic [GEN_BITS-1:0] look_gen;
   logic                handle_valid;
   logic [GEN_BITS-1:0] gen_inc;
   logic [GEN_BITS-1:0] gen_next;
   logic                claim_written;
   logic [GEN_BITS-1:0] claim_gen;

   gsa_slot_table #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS),
      .IDX_W    (IDX_W)
   ) u_slot_table (
      .clock   (clock),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_busy (tbl_wr_busy),
      .wr_gen  (tbl_wr_gen),
      .rd_busy (tbl_rd_busy),
      .rd_gen  (tbl_rd_gen)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Stack position of the next pop; only used while the stack is not empty.
   assign top_pos = free_top_ff - CNT_W'(1);
   assign pop_pos = top_pos[IDX_W-1:0];

   // Stack entries below the low-water mark were never pushed: they still hold
   // their reset contents, descending indices with the top yielding zero.
   always_comb begin
      logic [CNT_W-1:0] reset_word;
      reset_word = LAST_CNT - CNT_W'(pop_pos);
      if (CNT_W'(pop_pos) < low_mark_ff) begin
         pop_slot = reset_word[IDX_W-1:0];
      end else begin
         pop_slot = stack_rd_ff;
      end
   end

   // Slots below fresh_cnt have been handed out at least once and own a table entry;
   // all others read as not busy, generation zero.
   assign fresh_cnt     = SLOTS_CNT - low_mark_ff;
   assign in_range      = idx_ff < SLOTS_H;
   assign look_written  = CNT_W'(idx_ff[IDX_W-1:0]) < fresh_cnt;
   assign look_busy     = look_written && tbl_rd_busy;
   assign look_gen      = look_written ? tbl_rd_gen : '0;
   assign handle_valid  = in_range && look_busy && (CMP_W'(look_gen) == CMP_W'(hgen_ff));
   assign gen_inc       = look_gen + GEN_BITS'(1);
   assign gen_next      = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
   assign claim_written = CNT_W'(slot_ff) < fresh_cnt;
   assign claim_gen     = claim_written ? tbl_rd_gen : '0;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      slot_in       = slot_ff;
      free_top_in   = free_top_ff;
      low_mark_in   = low_mark_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_free_in   = rsp_free_ff;
      stack_rd_en   = 1'b0;
      stack_rd_addr = pop_pos;
      stack_wr_en   = 1'b0;
      stack_wr_addr = free_top_ff[IDX_W-1:0];
      stack_wr_data = idx_ff[IDX_W-1:0];
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = req_ch.handle_index[IDX_W-1:0];
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = idx_ff[IDX_W-1:0];
      tbl_wr_busy   = 1'b0;
      tbl_wr_gen    = gen_next;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = req_ch.action;
               idx_in  = req_ch.handle_index;
               hgen_in = req_ch.handle_generation;
               // fetch the stack top for an allocate, the slot entry for an in-range release or check
               stack_rd_en = (req_ch.action == ACT_ALLOC) && (free_top_ff != '0);
               tbl_rd_en   = ((req_ch.action == ACT_RELEASE) || (req_ch.action == ACT_CHECK))
                             && (req_ch.handle_index < SLOTS_H);
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            if ((act_ff == ACT_ALLOC) && (free_top_ff != '0)) begin
               // popped slot known: fetch its table entry
               slot_in     = pop_slot;
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = pop_slot;
               state_in    = S_CLAIM;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = '0;
               rsp_gen_in   = '0;
               rsp_free_in  = FREE_W'(free_top_ff);
               rsp_ok_in    = 1'b0;
               if ((act_ff == ACT_RELEASE) || (act_ff == ACT_CHECK)) begin
                  rsp_ok_in = handle_valid;
               end
               if ((act_ff == ACT_RELEASE) && handle_valid) begin
                  // retire the slot, advance its generation, push it back
                  tbl_wr_en = 1'b1;
                  if (free_top_ff < SLOTS_CNT) begin
                     stack_wr_en = 1'b1;
                     free_top_in = free_top_ff + CNT_W'(1);
                     rsp_free_in = FREE_W'(free_top_in);
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_CLAIM: begin
            if (out_free) begin
               tbl_wr_en    = 1'b1;
               tbl_wr_addr  = slot_ff;
               tbl_wr_busy  = 1'b1;
               tbl_wr_gen   = claim_gen;
               free_top_in  = top_pos;
               if (CNT_W'(pop_pos) < low_mark_ff) begin
                  low_mark_in = CNT_W'(pop_pos);
               end
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_idx_in   = OUT_IDX_W'(slot_ff);
               rsp_gen_in   = OUT_GEN_W'(claim_gen);
               rsp_free_in  = FREE_W'(top_pos);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[stack_wr_addr] <= stack_wr_data;
      end
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_top_ff  <= SLOTS_CNT;
         low_mark_ff  <= SLOTS_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_top_ff  <= free_top_in;
         low_mark_ff  <= low_mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      hgen_ff     <= hgen_in;
      slot_ff     <= slot_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_gen_ff  <= rsp_gen_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ok              = rsp_ok_ff;
   assign rsp_ch.slot_index      = rsp_idx_ff;
   assign rsp_ch.slot_generation = rsp_gen_ff;
   assign rsp_ch.free_slots      = rsp_free_ff;

endmodule

/* rtl/gsa_checker.sv */
// Port-level assertions for the generational slot allocator and their bind.
module gsa_checker #(
   parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_ok,
   input logic [gsa_pkg::OUT_IDX_W-1:0]  rsp_slot_index,
   input logic [gsa_pkg::OUT_GEN_W-1:0]  rsp_slot_generation,
   input logic [gsa_pkg::FREE_W-1:0]     rsp_free_slots
);
   import gsa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_slot_index)
         && $stable(rsp_slot_generation) && $stable(rsp_free_slots))
      else $error("response changed while stalled");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // no handle on a failed response
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_slot_index == '0) && (rsp_slot_generation == '0))
      else $error("failed response carries a handle");

   // free count within the pool
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_free_slots) <= SLOTS))
      else $error("free count beyond pool size");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind generational_slot_allocator gsa_checker #(.SLOTS(SLOTS)) u_gsa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_ok              (rsp_ch.ok),
   .rsp_slot_index      (rsp_ch.slot_index),
   .rsp_slot_generation (rsp_ch.slot_generation),
   .rsp_free_slots      (rsp_ch.free_slots)
);

/* tb/sv/gsa_pool_checker.sv */
// Response checker of the slot allocator: watches both channels, predicts each response, compares.
`timescale 1ns / 100ps
module gsa_pool_checker #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEFAULT,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   gsa_req_if   req_ch,
   gsa_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   results_due
);
   import gsa_pkg::*;

   typedef struct packed {
      logic                 ok;
      logic [OUT_IDX_W-1:0] slot_index;
      logic [OUT_GEN_W-1:0] slot_generation;
      logic [FREE_W-1:0]    free_slots;
   } pool_rsp_type;

   // Shadow of the pool: free stack, busy flags and generation tags.
   logic [OUT_IDX_W-1:0] free_list  [SLOTS];
   logic [FREE_W-1:0]    free_depth;
   logic                 slot_taken [SLOTS];
   logic [GEN_BITS-1:0]  slot_tag   [SLOTS];

   pool_rsp_type due[$];
   int           errors = 0;

   function automatic bit handle_live(logic [HANDLE_W-1:0] idx, logic [HANDLE_W-1:0] tag);
      return (int'(idx) < SLOTS) && slot_taken[idx] && (64'(slot_tag[idx]) == 64'(tag));
   endfunction

   // Apply one request to the shadow pool and return the response it must produce.
   function automatic pool_rsp_type apply_to_pool(action_type act, logic [HANDLE_W-1:0] idx,
                                                  logic [HANDLE_W-1:0] tag);
      pool_rsp_type         r;
      logic [OUT_IDX_W-1:0] s;
      logic [GEN_BITS-1:0]  bumped;
      bit                   live;
      r    = '0;
      live = handle_live(idx, tag);
      case (act)
         ACT_ALLOC: begin
            if (free_depth > 0) begin
               free_depth--;
               s                 = free_list[free_depth];
               slot_taken[s]     = 1'b1;
               r.ok              = 1'b1;
               r.slot_index      = s;
               r.slot_generation = OUT_GEN_W'(slot_tag[s]);
            end
         end
         ACT_RELEASE: begin
            if (live) begin
               slot_taken[idx] = 1'b0;
               bumped          = slot_tag[idx] + 1'b1;
               // skip zero on wrap
               if (bumped == '0) bumped = GEN_BITS'(1);
               slot_tag[idx] = bumped;
               if (free_depth < SLOTS) begin
                  free_list[free_depth] = OUT_IDX_W'(idx);
                  free_depth++;
               end
               r.ok = 1'b1;
            end
         end
         ACT_CHECK: r.ok = live;
         default: ;
      endcase
      r.free_slots = free_depth;
      return r;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      pool_rsp_type want;
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            free_list[k]  = OUT_IDX_W'(SLOTS - 1 - k);
            slot_taken[k] = 1'b0;
            slot_tag[k]   = '0;
         end
         free_depth = FREE_W'(SLOTS);
         due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due.size() == 0) begin
               errors++;
               $error("response with no request outstanding");
            end else begin
               want = due.pop_front();
               compare_field("ok", want.ok, rsp_ch.ok);
               compare_field("slot_index", want.slot_index, rsp_ch.slot_index);
               compare_field("slot_generation", want.slot_generation, rsp_ch.slot_generation);
               compare_field("free_slots", want.free_slots, rsp_ch.free_slots);
            end
         end
         if (req_ch.valid && req_ch.ready)
            due.push_back(apply_to_pool(req_ch.action, req_ch.handle_index,
                                        req_ch.handle_generation));
      end
      mismatch_count <= errors;
      results_due    <= due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top of the slot allocator: clock, reset, request stimulus, response pacing, verdict.
`timescale 1ns / 100ps
module tb_top;
   import gsa_pkg::*;

   // Code outside the three defined actions; the block must answer it with ok low.
   localparam action_type ACT_UNUSED      = 2'd3;
   localparam int         QUIET_LIMIT     = 1000;
   localparam int         RANDOM_REQUESTS = 1350;
   localparam int         RETIRED_DEPTH   = 32;
   localparam int         REUSE_ROUNDS    = 8;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] index;
      logic [OUT_GEN_W-1:0] tag;
   } handle_type;

   typedef enum {RX_OPEN, RX_LIGHT, RX_CADENCE, RX_HEAVY} rx_pattern_type;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   results_due;

   gsa_req_if req_ch();
   gsa_rsp_if rsp_ch();

   generational_slot_allocator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gsa_pool_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus-side knowledge of the pool: actions in flight, handles we hold, handles we gave back.
   action_type     in_flight[$];
   handle_type     held[$];
   handle_type     retired[$];
   bit             pace_on   = 1'b1;
   bit             stalls_on = 1'b1;
   bit             filling   = 1'b1;
   int             burst_left = 0;
   int             quiet      = 0;
   rx_pattern_type rx_mode    = RX_OPEN;
   int             rx_left    = 0;
   int             rx_tick    = 0;

   // Learn the handles the block hands out; a successful allocate response carries a live handle.
   always @(posedge clock) begin : track_handles
      action_type act;
      if (!reset && req_ch.valid && req_ch.ready) in_flight.push_back(req_ch.action);
      if (!reset && rsp_ch.valid && rsp_ch.ready && in_flight.size() != 0) begin
         act = in_flight.pop_front();
         if (act == ACT_ALLOC && rsp_ch.ok)
            held.push_back(handle_type'{rsp_ch.slot_index, rsp_ch.slot_generation});
      end
   end

   // Response side: switch at random between stall patterns.
   always @(posedge clock) begin : pace_responses
      logic take;
      if (rx_left == 0) begin
         rx_mode = rx_pattern_type'($urandom_range(3));
         rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:    take = 1'b1;
         RX_LIGHT:   take = ($urandom_range(99) < 70);
         RX_CADENCE: take = (rx_tick % 4 == 0);
         default:    take = ($urandom_range(99) < 20);
      endcase
      rsp_ch.ready <= reset ? 1'b0 : (take || !stalls_on);
   end

   // Drop the run if nothing moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("** generational_slot_allocator: FAILED **");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Drive one request and hold it until the block takes it. Valid stays high on return,
   // so the next call continues a burst; gaps open only between bursts.
   task automatic send_request(action_type act, logic [HANDLE_W-1:0] idx,
                               logic [HANDLE_W-1:0] tag);
      if (pace_on) begin
         if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_ch.valid             <= 1'b1;
      req_ch.action            <= act;
      req_ch.handle_index      <= idx;
      req_ch.handle_generation <= tag;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold the sender until every outstanding response has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // Give back the held handle at position k and remember it as stale.
   task automatic free_held(int k);
      handle_type h;
      h = held[k];
      held.delete(k);
      retired.push_back(h);
      if (retired.size() > RETIRED_DEPTH) void'(retired.pop_front());
      send_request(ACT_RELEASE, h.index, h.tag);
   endtask

   // Mostly well-formed traffic on live handles; the pool swings between empty and nearly full.
   task automatic issue_random();
      int         roll;
      int         k;
      handle_type h;
      action_type act;
      roll = $urandom_range(99);
      if (filling && held.size() >= SLOTS_DEFAULT) filling = 1'b0;
      else if (!filling && held.size() <= 4) filling = 1'b1;
      act = ($urandom_range(2) == 0) ? ACT_CHECK : ACT_RELEASE;
      if (roll < (filling ? 55 : 20) || (roll < 80 && held.size() == 0)) begin
         send_request(ACT_ALLOC, 16'($urandom), 16'($urandom));
      end else if (roll < 80) begin
         k = $urandom_range(held.size() - 1);
         if (act == ACT_RELEASE) free_held(k);
         else send_request(ACT_CHECK, held[k].index, held[k].tag);
      end else if (roll < 88 && retired.size() != 0) begin
         // stale handle: generation already advanced
         h = retired[$urandom_range(retired.size() - 1)];
         send_request(act, h.index, h.tag);
      end else if (roll < 95) begin
         // forged handle: any index, mostly wrong generation
         send_request(act,
                      $urandom_range(1) ? 16'($urandom_range(SLOTS_DEFAULT - 1)) : 16'($urandom),
                      $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom));
      end else begin
         send_request(ACT_UNUSED, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin : stimulus
      handle_type h;
      handle_type live;

      reset                    = 1'b1;
      req_ch.valid             = 1'b0;
      req_ch.action            = ACT_ALLOC;
      req_ch.handle_index      = '0;
      req_ch.handle_generation = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fresh pool: nothing is valid yet, unused code does nothing; then one allocate.
      send_request(ACT_CHECK, '0, '0);
      send_request(ACT_RELEASE, '0, '0);
      send_request(ACT_UNUSED, '1, '1);
      send_request(ACT_ALLOC, '1, '1);
      wait_drained();

      // Validity rules on one live handle: wrong generation, index out of range.
      h = held[0];
      send_request(ACT_CHECK, h.index, h.tag);
      send_request(ACT_CHECK, h.index, h.tag ^ 16'h0001);
      send_request(ACT_CHECK, 16'(SLOTS_DEFAULT), h.tag);
      send_request(ACT_CHECK, 16'hFFFF, h.tag);
      free_held(0);
      // double release and check of the now stale handle
      send_request(ACT_RELEASE, h.index, h.tag);
      send_request(ACT_CHECK, h.index, h.tag);

      // Empty the pool, then allocate past empty.
      repeat (SLOTS_DEFAULT + 2) send_request(ACT_ALLOC, 16'($urandom), 16'($urandom));
      wait_drained();
      h = held[$urandom_range(held.size() - 1)];
      send_request(ACT_CHECK, h.index, 16'hFFFF);
      // high index bits must not alias onto a busy slot
      send_request(ACT_RELEASE, 16'(SLOTS_DEFAULT) | 16'(h.index), h.tag);
      send_request(ACT_CHECK, 16'h8000 | 16'(h.index), h.tag);
      while (held.size() != 0) free_held($urandom_range(held.size() - 1));
      wait_drained();

      // Slot reuse: cycle one slot through release/allocate, back to back.
      // LIFO order hands the same slot straight back, so the next tag is known ahead.
      send_request(ACT_ALLOC, '0, '0);
      wait_drained();
      live      = held[$];
      pace_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (REUSE_ROUNDS) begin
         send_request(ACT_RELEASE, live.index, live.tag);
         send_request(ACT_ALLOC, '0, '0);
         live.tag = live.tag + 1'b1;
         if (live.tag == '0) live.tag = OUT_GEN_W'(1);
      end
      wait_drained();
      live = held[$];
      held.delete();
      held.push_back(live);
      pace_on   = 1'b1;
      stalls_on = 1'b1;
      send_request(ACT_CHECK, live.index, '0);
      send_request(ACT_CHECK, live.index, '1);
      send_request(ACT_CHECK, live.index, live.tag);

      for (int n = 0; n < RANDOM_REQUESTS; n++) issue_random();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("** generational_slot_allocator: PASSED **");
      end else begin
         $display("** generational_slot_allocator: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/gsa_pkg.sv
rtl/gsa_if.sv
rtl/gsa_slot_table.sv
rtl/generational_slot_allocator.sv
rtl/gsa_checker.sv
tb/sv/gsa_pool_checker.sv
tb/sv/tb_top.sv
